// ===== hw/rtl/latency_log2_histogram_monitor_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the monitor core, clocked on i_clk.
// ---------------------------------------------------------------------------
`ifndef LATENCY_LOG2_HISTOGRAM_MONITOR_CORE_ASSERT_SVH
`define LATENCY_LOG2_HISTOGRAM_MONITOR_CORE_ASSERT_SVH

// same-cycle implication
`define LLHM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("llhm assertion failed");

// next-cycle implication
`define LLHM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("llhm assertion failed");

`endif

// ===== hw/rtl/llhm_pkg.sv =====
// ---------------------------------------------------------------------------
// llhm_pkg
// Types, constants and helper functions of the latency histogram monitor.
// ---------------------------------------------------------------------------
package llhm_pkg;

    localparam int NUM_BUCKETS = 64;
    localparam int BKT_W       = 6;
    localparam logic [BKT_W-1:0] LAST_BUCKET = 6'd63;
    localparam int Q_DEPTH     = 4;
    localparam int Q_CNT_W     = 3;
    localparam int Q_PTR_W     = 2;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_PCT_A  = 2'd1;
    localparam logic [1:0] REG_PCT_B  = 2'd2;
    localparam logic [1:0] REG_PCT_C  = 2'd3;

    typedef struct packed {
        logic             op;
        logic             ok;      // metric id in range
        logic [4:0]       id;
        logic [63:0]      dur;
        logic [BKT_W-1:0] bkt;
    } t_entry;

    typedef struct packed {
        logic [31:0] calls;
        logic [63:0] sum;
        logic [63:0] peak;
    } t_stat;

    typedef struct packed {
        logic [6:0] pct_a;
        logic [6:0] pct_b;
        logic [6:0] pct_c;
    } t_cfg;

    typedef struct packed {
        logic        done;
        logic [4:0]  metric;
        logic [31:0] calls;
        logic [63:0] sum;
        logic [63:0] peak;
        logic [63:0] pct_a;
        logic [63:0] pct_b;
        logic [63:0] pct_c;
    } t_result;

    // bit width of v, capped at the last bucket
    function automatic logic [BKT_W-1:0] bucket_of(input logic [63:0] v);
        logic [6:0] w;
        w = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                w = 7'(i + 1);
            end
        end
        if (w > 7'(LAST_BUCKET)) begin
            w = 7'(LAST_BUCKET);
        end
        return w[BKT_W-1:0];
    endfunction

    function automatic logic [63:0] bucket_bound(input logic [BKT_W-1:0] b);
        if (b == '0) begin
            return 64'd0;
        end else if (b == LAST_BUCKET) begin
            return '1;
        end
        return 64'd1 << b;
    endfunction

endpackage

// ===== hw/rtl/latency_log2_histogram_monitor_core.sv =====
// ---------------------------------------------------------------------------
// latency_log2_histogram_monitor_core
// Per-metric call/latency statistics with log2 histogram and percentiles.
// ---------------------------------------------------------------------------
// After reset the block clears its bucket memory with busy high. Record
// commands are accepted back to back while busy is low; the read-modify-write on
// the bucket memory is forwarded.
// A readout waits for queued records, then walks the metric's 64 buckets one
// a cycle through the memory port.
// Results are pulsed for one cycle on o_done and cannot be held off.
module latency_log2_histogram_monitor_core #(
    parameter int NUM_METRICS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [4:0]  i_metric_id,
    input  logic [63:0] i_duration_ns,
    output logic        o_done,
    output logic [4:0]  o_out_metric,
    output logic [31:0] o_call_total,
    output logic [63:0] o_sum_ns,
    output logic [63:0] o_peak_ns,
    output logic [63:0] o_pct_a_ns,
    output logic [63:0] o_pct_b_ns,
    output logic [63:0] o_pct_c_ns,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import llhm_pkg::*;

    logic       r_enable;
    t_cfg       r_cfg;
    logic       clearing;
    logic       push, pop, q_empty;
    t_entry     f_entry, q_entry;
    logic [Q_CNT_W-1:0] q_count;
    t_result    res;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_cfg.pct_a <= 7'd50;
            r_cfg.pct_b <= 7'd95;
            r_cfg.pct_c <= 7'd99;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_ENABLE: r_enable    <= pwdata[0];
                REG_PCT_A:  r_cfg.pct_a <= pwdata[6:0];
                REG_PCT_B:  r_cfg.pct_b <= pwdata[6:0];
                REG_PCT_C:  r_cfg.pct_c <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ENABLE: prdata = {31'd0, r_enable};
            REG_PCT_A:  prdata = {25'd0, r_cfg.pct_a};
            REG_PCT_B:  prdata = {25'd0, r_cfg.pct_b};
            REG_PCT_C:  prdata = {25'd0, r_cfg.pct_c};
            default:    prdata = '0;
        endcase
    end

    llhm_front #(.NUM_METRICS(NUM_METRICS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(start), .i_opcode(i_opcode), .i_metric_id(i_metric_id),
        .i_duration_ns(i_duration_ns), .i_enable(r_enable),
        .i_clearing(clearing), .i_q_count(q_count),
        .o_busy(busy), .o_push(push), .o_entry(f_entry)
    );

    llhm_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_entry(f_entry), .i_pop(pop),
        .o_entry(q_entry), .o_empty(q_empty), .o_count(q_count)
    );

    llhm_back #(.NUM_METRICS(NUM_METRICS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_entry(q_entry), .i_empty(q_empty), .i_cfg(r_cfg),
        .o_pop(pop), .o_clearing(clearing), .o_result(res)
    );

    assign o_done       = res.done;
    assign o_out_metric = res.metric;
    assign o_call_total = res.calls;
    assign o_sum_ns     = res.sum;
    assign o_peak_ns    = res.peak;
    assign o_pct_a_ns   = res.pct_a;
    assign o_pct_b_ns   = res.pct_b;
    assign o_pct_c_ns   = res.pct_c;

endmodule

// ===== hw/rtl/llhm_queue.sv =====
// ---------------------------------------------------------------------------
// llhm_queue
// Short FIFO between the classifier and the statistics engine.
// ---------------------------------------------------------------------------
module llhm_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  llhm_pkg::t_entry        i_entry,
    input  logic                    i_pop,
    output llhm_pkg::t_entry        o_entry,
    output logic                    o_empty,
    output logic [llhm_pkg::Q_CNT_W-1:0] o_count
);
    import llhm_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

// ===== hw/rtl/llhm_front.sv =====
// ---------------------------------------------------------------------------
// llhm_front
// Takes commands, drops disabled or out-of-range records, finds the bucket.
// ---------------------------------------------------------------------------
module llhm_front #(
    parameter int NUM_METRICS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_opcode,
    input  logic [4:0]              i_metric_id,
    input  logic [63:0]             i_duration_ns,
    input  logic                    i_enable,
    input  logic                    i_clearing,
    input  logic [llhm_pkg::Q_CNT_W-1:0] i_q_count,
    output logic                    o_busy,
    output logic                    o_push,
    output llhm_pkg::t_entry        o_entry
);
    import llhm_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    logic   ok;
    logic   take;

    // room for the staged command and a new one
    assign o_busy = i_clearing ||
                    ((i_q_count + Q_CNT_W'(r_valid)) >= Q_CNT_W'(Q_DEPTH));
    assign ok     = 9'(i_metric_id) < 9'(NUM_METRICS);
    assign take   = i_start && !o_busy &&
                    ((i_opcode == OP_READ) || (i_enable && ok));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_entry.op  <= i_opcode;
            r_entry.ok  <= ok;
            r_entry.id  <= i_metric_id;
            r_entry.dur <= i_duration_ns;
            r_entry.bkt <= bucket_of(i_duration_ns);
        end
    end

    assign o_push  = r_valid;
    assign o_entry = r_entry;

endmodule

// ===== hw/rtl/llhm_back.sv =====
// ---------------------------------------------------------------------------
// llhm_back
// Statistics engine: record read-modify-write, readout bucket walk, clearing.
// ---------------------------------------------------------------------------
`include "latency_log2_histogram_monitor_core_assert.svh"

module llhm_back #(
    parameter int NUM_METRICS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  llhm_pkg::t_entry    i_entry,
    input  logic                i_empty,
    input  llhm_pkg::t_cfg      i_cfg,
    output logic                o_pop,
    output logic                o_clearing,
    output llhm_pkg::t_result   o_result
);
    import llhm_pkg::*;

    localparam int MW    = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
    localparam int AW    = MW + BKT_W;
    localparam int DEPTH = NUM_METRICS * NUM_BUCKETS;

    typedef enum logic [1:0] {ST_CLR, ST_IDLE, ST_LD, ST_WALK} t_state;

    logic [31:0] r_bkt_mem  [DEPTH];
    t_stat       r_stat_mem [NUM_METRICS];
    logic [31:0] r_bkt_rd;
    t_stat       r_stat_rd;

    t_state          r_state;
    logic [AW-1:0]   r_clr;
    // record stage
    logic            r_s1_v;
    logic [MW-1:0]   r_s1_row;
    logic [BKT_W-1:0] r_s1_bkt;
    logic [63:0]     r_s1_dur;
    logic            r_fw_stat_hit;
    logic            r_fw_bkt_hit;
    t_stat           r_fw_stat;
    logic [31:0]     r_fw_bkt;
    // readout
    logic [MW-1:0]   r_row;
    logic [4:0]      r_id;
    logic [BKT_W-1:0] r_b;
    logic            r_issue_done;
    logic            r_dv;
    logic [BKT_W-1:0] r_db;
    logic [31:0]     r_calls;
    logic [63:0]     r_sum;
    logic [63:0]     r_peak;
    logic [38:0]     r_prod_a, r_prod_b, r_prod_c;
    logic [37:0]     r_seen;
    logic [44:0]     r_s100;
    logic            r_fnd_a, r_fnd_b, r_fnd_c;
    logic [63:0]     r_res_a, r_res_b, r_res_c;
    t_result         r_out;

    logic            rec_go, rd_go;
    logic            n_done;
    logic [MW-1:0]   in_row;
    t_stat           cur_stat, new_stat;
    logic [31:0]     cur_bkt, new_bkt;
    logic            bkt_we, stat_we;
    logic [AW-1:0]   bkt_waddr, bkt_raddr;
    logic [MW-1:0]   stat_waddr;
    logic [31:0]     bkt_wdata;
    t_stat           stat_wdata;
    logic [37:0]     n_seen;
    logic [44:0]     n_s100;
    logic            hit_a, hit_b, hit_c;
    logic            n_fnd_a, n_fnd_b, n_fnd_c;
    logic [63:0]     n_res_a, n_res_b, n_res_c;
    logic [63:0]     bound;

    assign in_row = MW'(i_entry.id);
    assign rec_go = (r_state == ST_IDLE) && !i_empty && (i_entry.op == OP_RECORD);
    assign rd_go  = (r_state == ST_IDLE) && !i_empty && (i_entry.op == OP_READ) && !r_s1_v;
    assign o_pop  = rec_go || rd_go;
    assign o_clearing = (r_state == ST_CLR);

    // result strobe: out-of-range readout at once, else at the last bucket of the walk
    assign n_done = (rd_go && !i_entry.ok) ||
                    ((r_state == ST_WALK) && r_dv && (r_db == LAST_BUCKET));

    // record update, with forwarding from the write of the cycle before
    always_comb begin
        cur_stat = r_fw_stat_hit ? r_fw_stat : r_stat_rd;
        cur_bkt  = r_fw_bkt_hit ? r_fw_bkt : r_bkt_rd;
        new_stat.calls = (cur_stat.calls == SAT32) ? SAT32 : cur_stat.calls + 32'd1;
        new_stat.sum   = cur_stat.sum + r_s1_dur;
        new_stat.peak  = (r_s1_dur > cur_stat.peak) ? r_s1_dur : cur_stat.peak;
        new_bkt        = (cur_bkt == SAT32) ? SAT32 : cur_bkt + 32'd1;
    end

    always_comb begin
        bkt_we     = 1'b0;
        bkt_waddr  = {r_s1_row, r_s1_bkt};
        bkt_wdata  = new_bkt;
        stat_we    = 1'b0;
        stat_waddr = r_s1_row;
        stat_wdata = new_stat;
        if (r_state == ST_CLR) begin
            bkt_we     = 1'b1;
            bkt_waddr  = r_clr;
            bkt_wdata  = '0;
            stat_we    = 32'(r_clr) < 32'(NUM_METRICS);
            stat_waddr = MW'(r_clr);
            stat_wdata = '0;
        end else if (r_state == ST_LD) begin
            stat_we    = 1'b1;
            stat_waddr = r_row;
            stat_wdata = '0;
        end else if (r_state == ST_WALK) begin
            bkt_we    = !r_issue_done;
            bkt_waddr = {r_row, r_b};
            bkt_wdata = '0;
        end else if (r_s1_v) begin
            bkt_we  = 1'b1;
            stat_we = 1'b1;
        end
        bkt_raddr = (r_state == ST_WALK) ? {r_row, r_b} : {in_row, i_entry.bkt};
    end

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            r_bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        r_bkt_rd <= r_bkt_mem[bkt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stat_we) begin
            r_stat_mem[stat_waddr] <= stat_wdata;
        end
        r_stat_rd <= r_stat_mem[in_row];
    end

    // percentile search: seen >= ceil(calls*pct/100) as 100*seen >= calls*pct
    always_comb begin
        n_seen = r_seen + 38'(r_bkt_rd);
        n_s100 = r_s100 + 45'(r_bkt_rd) * 45'd100;
        bound  = bucket_bound(r_db);
        hit_a  = (n_seen != '0) && (n_s100 >= 45'(r_prod_a));
        hit_b  = (n_seen != '0) && (n_s100 >= 45'(r_prod_b));
        hit_c  = (n_seen != '0) && (n_s100 >= 45'(r_prod_c));
        n_fnd_a = r_fnd_a || hit_a;
        n_fnd_b = r_fnd_b || hit_b;
        n_fnd_c = r_fnd_c || hit_c;
        n_res_a = r_fnd_a ? r_res_a : (hit_a ? bound : '1);
        n_res_b = r_fnd_b ? r_res_b : (hit_b ? bound : '1);
        n_res_c = r_fnd_c ? r_res_c : (hit_c ? bound : '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_s1_v   <= 1'b0;
            r_dv     <= 1'b0;
            r_out.done <= 1'b0;
            r_fw_stat_hit <= 1'b0;
            r_fw_bkt_hit  <= 1'b0;
        end else begin
            r_out.done <= n_done;
            r_s1_v     <= rec_go;
            r_fw_stat_hit <= rec_go && r_s1_v && (r_s1_row == in_row);
            r_fw_bkt_hit  <= rec_go && r_s1_v && (r_s1_row == in_row) &&
                             (r_s1_bkt == i_entry.bkt);
            r_fw_stat <= new_stat;
            r_fw_bkt  <= new_bkt;
            if (rec_go) begin
                r_s1_row <= in_row;
                r_s1_bkt <= i_entry.bkt;
                r_s1_dur <= i_entry.dur;
            end
            unique case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == 32'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (rd_go) begin
                        r_row <= in_row;
                        r_id  <= i_entry.id;
                        if (i_entry.ok) begin
                            r_state <= ST_LD;
                        end else begin
                            r_out.metric <= i_entry.id;
                            r_out.calls  <= '0;
                            r_out.sum    <= '0;
                            r_out.peak   <= '0;
                            r_out.pct_a  <= '0;
                            r_out.pct_b  <= '0;
                            r_out.pct_c  <= '0;
                        end
                    end
                end
                ST_LD: begin
                    r_calls  <= r_stat_rd.calls;
                    r_sum    <= r_stat_rd.sum;
                    r_peak   <= r_stat_rd.peak;
                    r_prod_a <= 39'(r_stat_rd.calls) * 39'(i_cfg.pct_a);
                    r_prod_b <= 39'(r_stat_rd.calls) * 39'(i_cfg.pct_b);
                    r_prod_c <= 39'(r_stat_rd.calls) * 39'(i_cfg.pct_c);
                    r_seen   <= '0;
                    r_s100   <= '0;
                    r_fnd_a  <= 1'b0;
                    r_fnd_b  <= 1'b0;
                    r_fnd_c  <= 1'b0;
                    r_b      <= '0;
                    r_issue_done <= 1'b0;
                    r_state  <= ST_WALK;
                end
                ST_WALK: begin
                    // drops to zero after the last bucket is issued
                    r_dv <= !r_issue_done;
                    r_db <= r_b;
                    if (!r_issue_done) begin
                        r_b <= r_b + 1'b1;
                        r_issue_done <= (r_b == LAST_BUCKET);
                    end
                    if (r_dv) begin
                        r_seen  <= n_seen;
                        r_s100  <= n_s100;
                        r_fnd_a <= n_fnd_a;
                        r_fnd_b <= n_fnd_b;
                        r_fnd_c <= n_fnd_c;
                        r_res_a <= n_res_a;
                        r_res_b <= n_res_b;
                        r_res_c <= n_res_c;
                        if (r_db == LAST_BUCKET) begin
                            r_state      <= ST_IDLE;
                            r_out.metric <= r_id;
                            r_out.calls  <= r_calls;
                            r_out.sum    <= r_sum;
                            r_out.peak   <= r_peak;
                            r_out.pct_a  <= (r_calls == '0) ? '0 : n_res_a;
                            r_out.pct_b  <= (r_calls == '0) ? '0 : n_res_b;
                            r_out.pct_c  <= (r_calls == '0) ? '0 : n_res_c;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_result = r_out;

    `LLHM_ASSERT_IMP(a_no_pop_clearing, r_state == ST_CLR, !o_pop)
    `LLHM_ASSERT_IMP(a_no_rec_in_walk, r_state == ST_WALK || r_state == ST_LD, !r_s1_v)
    `LLHM_ASSERT_IMP(a_zero_calls_zero_pct, r_out.done && r_out.calls == '0,
        r_out.pct_a == '0 && r_out.pct_b == '0 && r_out.pct_c == '0)
    `LLHM_ASSERT_NXT(a_done_single, r_out.done, !r_out.done || $past(r_state) == ST_IDLE)

endmodule
